// File: rtl/sd_cartridge_bus_decoder_unit_assert.svh
// Assertion macros for the cartridge bus decoder.
// Used by the checker module; needs no other file.
`ifndef SD_CARTRIDGE_BUS_DECODER_UNIT_ASSERT_SVH
`define SD_CARTRIDGE_BUS_DECODER_UNIT_ASSERT_SVH

// Assertion sampled on the rising clock, off while reset is held.
`define SDCBD_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("sdcbd assertion failed");

// Assertion that also holds while reset is held.
`define SDCBD_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("sdcbd assertion failed");

`endif

// File: rtl/sdcbd_pkg.sv
// Package for the cartridge bus decoder: codes, constants and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdcbd_pkg;
	// Action codes.
	localparam logic [2:0] ACT_MEM_RD  = 3'd0;
	localparam logic [2:0] ACT_MEM_WR  = 3'd1;
	localparam logic [2:0] ACT_IO_RD   = 3'd2;
	localparam logic [2:0] ACT_IO_WR   = 3'd3;
	localparam logic [2:0] ACT_SLOT_RD = 3'd4;
	localparam logic [2:0] ACT_SLOT_WR = 3'd5;
	localparam logic [2:0] ACT_TICK    = 3'd6;

	// Result target codes.
	localparam logic [2:0] TGT_NONE = 3'd0;
	localparam logic [2:0] TGT_REG  = 3'd1;
	localparam logic [2:0] TGT_ROM  = 3'd2;
	localparam logic [2:0] TGT_RAM  = 3'd3;
	localparam logic [2:0] TGT_CARD = 3'd4;

	// Register indexes.
	localparam logic [1:0] REG_ROM_MODE = 2'd0;
	localparam logic [1:0] REG_MAPPER   = 2'd1;
	localparam logic [1:0] REG_ALT_DRV  = 2'd2;
	localparam logic [1:0] REG_CPU_HZ   = 2'd3;

	localparam int DRIVER_BANKS_DEF = 8;
	localparam int RAM_SEGMENTS_DEF = 32;

	localparam logic [26:0] CPU_HZ_RESET = 27'd3579545;
	localparam logic [24:0] TIMER_HZ     = 25'd25000000;
	localparam int          DIVIDEND_W   = 41;
	localparam int          DIV_STEPS    = 41;

	// Register file contents handed to the datapath.
	typedef struct packed {
		logic [1:0]  rom_mode;
		logic        map_en;
		logic        alt_drv;
		logic [26:0] cpu_hz;
	} cfg_t;

	// Controller commands.
	typedef struct packed {
		logic load;
		logic commit;
		logic mul;
		logic div_step;
		logic fin;
	} cmd_t;

	// Datapath status.
	typedef struct packed {
		logic need_div;
	} sts_t;
endpackage
`default_nettype wire

// File: rtl/sdcbd_if.sv
// Request and result channel interfaces for the cartridge bus decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sdcbd_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [15:0] address;
	logic [7:0]  data;
	logic [1:0]  io_page;
	logic [15:0] cycles;
	logic [1:0]  card_writable;
	logic [1:0]  card_mounted;
	logic [1:0]  card_media_changed;
	modport source (output valid, action, address, data, io_page, cycles,
		card_writable, card_mounted, card_media_changed, input ready);
	modport sink (input valid, action, address, data, io_page, cycles,
		card_writable, card_mounted, card_media_changed, output ready);
endinterface

interface sdcbd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [2:0]  target;
	logic [18:0] mem_offset;
	logic [7:0]  card_tx;
	logic [1:0]  card_select;
	logic [1:0]  clear_media;
	modport source (output valid, read_data, target, mem_offset, card_tx,
		card_select, clear_media, input ready);
	modport sink (input valid, read_data, target, mem_offset, card_tx,
		card_select, clear_media, output ready);
endinterface
`default_nettype wire

// File: rtl/sdcbd_ctrl.sv
// Controller of the cartridge bus decoder: sequences request intake, result
// hand-off and the tick divider. Depends on sdcbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdcbd_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  sdcbd_pkg::sts_t   sts,
	output sdcbd_pkg::cmd_t   cmd
);
	import sdcbd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.commit   = (state_q == ST_EXEC) && slot_free;
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.fin      = (state_q == ST_FIN);
	end

	// State sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (slot_free) state_q <= sts.need_div ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					if (cnt_q == 6'(DIV_STEPS - 1)) state_q <= ST_FIN;
					cnt_q <= cnt_q + 6'd1;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// File: rtl/sdcbd_dp.sv
// Datapath of the cartridge bus decoder: request registers, slot and mapper
// state, address decode, result register and the serial tick divider.
// Depends on sdcbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdcbd_dp #(
	parameter int DRIVER_BANKS = sdcbd_pkg::DRIVER_BANKS_DEF,
	parameter int RAM_SEGMENTS = sdcbd_pkg::RAM_SEGMENTS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  sdcbd_pkg::cfg_t  cfg,
	input  wire              cfg_clear,
	input  sdcbd_pkg::cmd_t  cmd,
	output sdcbd_pkg::sts_t  sts,
	input  wire [2:0]        in_action,
	input  wire [15:0]       in_address,
	input  wire [7:0]        in_data,
	input  wire [1:0]        in_io_page,
	input  wire [15:0]       in_cycles,
	input  wire [1:0]        in_card_writable,
	input  wire [1:0]        in_card_mounted,
	input  wire [1:0]        in_card_media_changed,
	output logic [7:0]       read_data,
	output logic [2:0]       target,
	output logic [18:0]      mem_offset,
	output logic [7:0]       card_tx,
	output logic [1:0]       card_select,
	output logic [1:0]       clear_media
);
	import sdcbd_pkg::*;

	localparam logic [19:0] DRV_BYTES = 20'(DRIVER_BANKS * 16384);
	localparam logic [5:0]  SEGS      = 6'(RAM_SEGMENTS);

	// Request registers.
	logic [2:0]  act_q;
	logic [15:0] addr_q;
	logic [7:0]  data_q;
	logic [1:0]  page_q;
	logic [15:0] cyc_q;
	logic [1:0]  wr_q, mnt_q, mc_q;

	// Block state.
	logic [7:0]  slot_q;
	logic [4:0]  seg_q [4];
	logic [2:0]  p1_q;
	logic [3:0]  p2_q;
	logic [1:0]  sel_q;
	logic [15:0] cd_q;
	logic [26:0] frac_q;

	// Divider.
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [26:0]           rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= in_action;
			addr_q <= in_address;
			data_q <= in_data;
			page_q <= in_io_page;
			cyc_q  <= in_cycles;
			wr_q   <= in_card_writable;
			mnt_q  <= in_card_mounted;
			mc_q   <= in_card_media_changed;
		end
	end

	// Decode of the held request against current state.
	logic        loaded, full_rom, one_card, win;
	logic [1:0]  sub, seg_idx;
	logic [4:0]  seg_val, seg_mod;
	logic [2:0]  bank;
	logic        rom_hit;
	logic [19:0] rom_off, rom_len, rom_base;
	logic [7:0]  o_rd, o_tx, n_slot;
	logic [2:0]  o_tgt;
	logic [18:0] o_off;
	logic [1:0]  o_clr, n_sel;
	logic        seg_we, p1_we, p2_we, cd_we;

	assign loaded   = (cfg.rom_mode != 2'd0);
	assign full_rom = cfg.rom_mode[1];
	assign rom_len  = full_rom ? {DRV_BYTES[18:0], 1'b0} : (loaded ? DRV_BYTES : 20'd0);
	assign rom_base = (full_rom && cfg.alt_drv) ? DRV_BYTES : 20'd0;
	assign one_card = (sel_q == 2'd1) || (sel_q == 2'd2);
	assign win      = (p1_q == 3'd7) && (addr_q >= 16'h7b00) && (addr_q < 16'h7f00);
	assign seg_idx  = ((act_q == ACT_IO_RD) || (act_q == ACT_IO_WR)) ? page_q : addr_q[15:14];
	assign seg_val  = seg_q[seg_idx];
	assign bank     = (addr_q[15:14] == 2'd1) ? p1_q : p2_q[2:0];
	assign rom_off  = rom_base + {3'd0, bank, addr_q[13:0]};
	assign rom_hit  = (rom_off < rom_len);
	assign sts.need_div = (act_q == ACT_TICK) && (cd_q != 16'd0) && (cfg.cpu_hz != 27'd0);

	// Subslot of the addressed page.
	always_comb begin
		case (addr_q[15:14])
			2'd0:    sub = slot_q[1:0];
			2'd1:    sub = slot_q[3:2];
			2'd2:    sub = slot_q[5:4];
			default: sub = slot_q[7:6];
		endcase
		if (!cfg.map_en) sub = 2'd0;
	end

	// Segment number wrapped to the fitted RAM size.
	always_comb begin
		logic [5:0] v;
		v = {1'b0, seg_val};
		for (int i = 0; i < 8; i++) begin
			if (v >= SEGS) v = v - SEGS;
		end
		seg_mod = v[4:0];
	end

	// Per-action result and state update.
	always_comb begin
		o_rd   = 8'hff;
		o_tgt  = TGT_NONE;
		o_off  = '0;
		o_tx   = 8'hff;
		o_clr  = 2'd0;
		n_sel  = sel_q;
		n_slot = slot_q;
		seg_we = 1'b0;
		p1_we  = 1'b0;
		p2_we  = 1'b0;
		cd_we  = 1'b0;
		unique case (act_q) inside
			ACT_MEM_RD, ACT_MEM_WR: begin
				if (loaded && sub == 2'd1) begin
					o_tgt = TGT_RAM;
					o_off = {seg_mod, addr_q[13:0]};
				end else if (loaded && sub == 2'd0) begin
					if (win) begin
						if (one_card) begin
							o_tgt = TGT_CARD;
							o_tx  = (act_q == ACT_MEM_WR) ? data_q : 8'hff;
						end
					end else if (act_q == ACT_MEM_RD) begin
						if (addr_q == 16'h7ff0) begin
							o_tgt = TGT_REG;
							if (sel_q == 2'd0) begin
								o_rd = {6'd0, cfg.alt_drv, cfg.map_en};
							end else if (one_card) begin
								o_rd  = {5'd0, ~|(wr_q & sel_q), ~|(mnt_q & sel_q),
									|(mc_q & sel_q)};
								o_clr = sel_q;
							end
						end else if (addr_q == 16'h7ff1) begin
							o_tgt = TGT_REG;
							o_rd  = cd_q[15:8];
						end else if ((addr_q[15:14] == 2'd1 ||
								(addr_q[15:14] == 2'd2 && p2_q[3])) && rom_hit) begin
							o_tgt = TGT_ROM;
							o_off = rom_off[18:0];
						end
					end else begin
						if (addr_q == 16'h7ff0) begin
							n_sel = data_q[1:0];
						end else if (addr_q == 16'h7ff1) begin
							cd_we = 1'b1;
						end else if ((addr_q & 16'he800) == 16'h6000) begin
							p2_we = addr_q[12];
							p1_we = !addr_q[12];
						end
					end
				end
			end
			ACT_IO_RD: begin
				if (loaded && cfg.map_en) begin
					o_tgt = TGT_REG;
					o_rd  = {3'b111, seg_val};
				end
			end
			ACT_IO_WR: begin
				seg_we = loaded && cfg.map_en;
			end
			ACT_SLOT_RD: begin
				o_tgt = TGT_REG;
				o_rd  = ~slot_q;
			end
			ACT_SLOT_WR: begin
				n_slot = data_q;
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			read_data   <= o_rd;
			target      <= o_tgt;
			mem_offset  <= o_off;
			card_tx     <= o_tx;
			card_select <= n_sel;
			clear_media <= o_clr;
		end
	end

	// Divider step.
	logic [27:0] trial;
	logic        ge;
	assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
	assign ge    = (trial >= {1'b0, cfg.cpu_hz});

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			seg_q  <= '{5'd3, 5'd2, 5'd1, 5'd0};
			p1_q   <= '0;
			p2_q   <= '0;
			sel_q  <= '0;
			cd_q   <= '0;
			frac_q <= '0;
		end else if (cfg_clear) begin
			slot_q <= '0;
			seg_q  <= '{5'd3, 5'd2, 5'd1, 5'd0};
			p1_q   <= '0;
			p2_q   <= '0;
			sel_q  <= '0;
			cd_q   <= '0;
			frac_q <= '0;
		end else if (cmd.commit) begin
			slot_q <= n_slot;
			sel_q  <= n_sel;
			if (seg_we) seg_q[page_q] <= data_q[4:0];
			if (p1_we) p1_q <= data_q[2:0];
			if (p2_we) p2_q <= data_q[3:0];
			if (cd_we) begin
				cd_q   <= {data_q, 8'hff};
				frac_q <= '0;
			end
		end else if (cmd.fin) begin
			cd_q   <= (dvd_q >= {25'd0, cd_q}) ? 16'd0 : cd_q - dvd_q[15:0];
			frac_q <= rem_q;
		end
	end

	// Dividend and remainder of the tick scaling.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			dvd_q <= ({25'd0, cyc_q} * {16'd0, TIMER_HZ}) + {14'd0, frac_q};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? 27'(trial - {1'b0, cfg.cpu_hz}) : trial[26:0];
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire

// File: rtl/sd_cartridge_bus_decoder_unit.sv
// Cartridge bus decoder for a two-card storage cartridge.
// Requests arrive on the item channel (valid/ready); one result per request
// leaves on the result channel (valid/ready) in request order.
// Bus requests (memory, mapper port, slot register) are held in the request
// registers and loaded into the output register from the execute state;
// the controller then returns to idle and accepts the next request.
// A tick request also loads its result from the execute state; then, if the
// countdown and cpu_hz are nonzero, it scales the cycle count to 25 MHz with
// a multiply and a restoring divider by cpu_hz (one quotient bit per cycle).
// The output register holds a finished result while the receiver stalls; a
// new request is still taken, but its result waits until the register frees.
// Configuration is an APB write port: rom_mode at 0x0, the mapper enable at
// 0x4, the alternate driver select at 0x8, cpu_hz at 0xC; every write also
// resets the slot, mapper, bank, card and timer state. Reset (arst_n low)
// clears all of it and loads the register defaults. Depends on sdcbd_pkg,
// sdcbd_if, sdcbd_ctrl and sdcbd_dp.
`timescale 1ns / 1ps
`default_nettype none
module sd_cartridge_bus_decoder_unit #(
	parameter int DRIVER_BANKS = sdcbd_pkg::DRIVER_BANKS_DEF,
	parameter int RAM_SEGMENTS = sdcbd_pkg::RAM_SEGMENTS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	sdcbd_in_if.sink     item,
	sdcbd_out_if.source  result,
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [3:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import sdcbd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	// Register file writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rom_mode <= 2'd0;
			cfg_q.map_en   <= 1'b1;
			cfg_q.alt_drv  <= 1'b0;
			cfg_q.cpu_hz   <= CPU_HZ_RESET;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_ROM_MODE: cfg_q.rom_mode <= pwdata[1:0];
				REG_MAPPER:   cfg_q.map_en   <= pwdata[0];
				REG_ALT_DRV:  cfg_q.alt_drv  <= pwdata[0];
				REG_CPU_HZ:   cfg_q.cpu_hz   <= pwdata[26:0];
				default:      cfg_q.rom_mode <= cfg_q.rom_mode;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (paddr[3:2])
			REG_ROM_MODE: prdata = {30'd0, cfg_q.rom_mode};
			REG_MAPPER:   prdata = {31'd0, cfg_q.map_en};
			REG_ALT_DRV:  prdata = {31'd0, cfg_q.alt_drv};
			REG_CPU_HZ:   prdata = {5'd0, cfg_q.cpu_hz};
			default:      prdata = '0;
		endcase
	end

	sdcbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sdcbd_dp #(
		.DRIVER_BANKS (DRIVER_BANKS),
		.RAM_SEGMENTS (RAM_SEGMENTS)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg                   (cfg_q),
		.cfg_clear             (cfg_we),
		.cmd                   (cmd),
		.sts                   (sts),
		.in_action             (item.action),
		.in_address            (item.address),
		.in_data               (item.data),
		.in_io_page            (item.io_page),
		.in_cycles             (item.cycles),
		.in_card_writable      (item.card_writable),
		.in_card_mounted       (item.card_mounted),
		.in_card_media_changed (item.card_media_changed),
		.read_data             (result.read_data),
		.target                (result.target),
		.mem_offset            (result.mem_offset),
		.card_tx               (result.card_tx),
		.card_select           (result.card_select),
		.clear_media           (result.clear_media)
	);
endmodule
`default_nettype wire

// File: rtl/sdcbd_chk.sv
// Port-level checker for the cartridge bus decoder, bound to the top level.
// Depends on sdcbd_pkg and sd_cartridge_bus_decoder_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sd_cartridge_bus_decoder_unit_assert.svh"
module sdcbd_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [7:0]  read_data,
	input wire [2:0]  target,
	input wire [18:0] mem_offset,
	input wire [7:0]  card_tx
);
	import sdcbd_pkg::*;

	// A stalled result keeps its target, offset and read data.
	`SDCBD_ASSERT(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(target) && $stable(mem_offset) && $stable(read_data))
	// One request at a time: intake closes right after an accepted request.
	`SDCBD_ASSERT(a_one, clk, arst_n, in_valid && in_ready |=> !in_ready)
	// Offsets only accompany ROM or RAM results.
	`SDCBD_ASSERT(a_off, clk, arst_n, out_valid && target != TGT_ROM && target != TGT_RAM |-> mem_offset == 19'd0)
	// Register data only accompanies register results.
	`SDCBD_ASSERT(a_rd, clk, arst_n, out_valid && target != TGT_REG |-> read_data == 8'hff)
	// Card byte only accompanies card exchanges.
	`SDCBD_ASSERT(a_tx, clk, arst_n, out_valid && target != TGT_CARD |-> card_tx == 8'hff)
endmodule

bind sd_cartridge_bus_decoder_unit sdcbd_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.read_data  (result.read_data),
	.target     (result.target),
	.mem_offset (result.mem_offset),
	.card_tx    (result.card_tx)
);
`default_nettype wire
